### rtl/crt_pkg.sv
// Shared types and request kind codes for the coalescing range table.
`timescale 1ns / 1ps
package crt_pkg;

  // Width of a byte position inside the table.
  localparam int POS_BITS = 40;

  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_LOOKUP = 2'd1;
  localparam logic [1:0] KIND_INFO   = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Result fields handed from the sequencer to the output register.
  typedef struct packed {
    logic        hit;
    logic [39:0] range_start;
    logic [39:0] range_size;
    logic [39:0] available;
    logic        enough;
    logic        status;
  } result_t;

endpackage

### rtl/crt_ram.sv
// Synchronous one-read one-write range memory: start and end of each entry.
`timescale 1ns / 1ps
module crt_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 80
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### rtl/coalescing_range_table_top.sv
// Top level of the coalescing range table: sequencer over a range memory.
//
//  channel | direction | signals
//  --------+-----------+-----------------------------------------------------
//  request | in        | req_valid_i, req_stall_o, kind_i, position_i, length_i
//  result  | out       | res_valid_o, res_stall_i, hit_o, range_start_o,
//          |           | range_size_o, available_o, enough_o, status_o
//
// A request scans every stored entry through the registered memory read: an
// accept step, a scan over all stored entries and a result step. A write that
// extends or inserts adds a rewrite pass over the entries after the affected
// one and a flush write step. No new request is taken until the sequencer is
// back in idle. The count sits in a register cleared by reset, so the memory
// needs no clearing pass. A stalled result holds in its register; the next
// request is taken meanwhile and waits in its result or flush step until that
// register frees.
`timescale 1ns / 1ps
module coalescing_range_table_top #(
  parameter int MAX_RANGES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [39:0] position_i,
  input  logic [31:0] length_i,
  output logic        res_valid_o,
  input  logic        res_stall_i,
  output logic        hit_o,
  output logic [39:0] range_start_o,
  output logic [39:0] range_size_o,
  output logic [39:0] available_o,
  output logic        enough_o,
  output logic        status_o
);

  localparam int PW = crt_pkg::POS_BITS;
  localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CW = $clog2(MAX_RANGES + 1);
  localparam logic [PW:0]   PMAX = {1'b0, {PW{1'b1}}};
  localparam logic [CW-1:0] FULL = CW'(MAX_RANGES);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DONE, S_PASS, S_FLUSH
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   ri_q, ri_d;        // read index issued
  logic [CW-1:0]   wi_q, wi_d;        // index of the entry in read data
  logic            rv_q, rv_d;        // read data valid
  logic [1:0]      kind_q, kind_d;
  logic [PW-1:0]   pos_q, pos_d;
  logic [31:0]     len_q, len_d;
  logic [PW-1:0]   nend_q, nend_d;
  // search outcome
  logic            found_q, found_d, first0_q, first0_d;
  logic [CW-1:0]   fidx_q, fidx_d, ins_q, ins_d;
  logic [PW-1:0]   fs_q, fs_d, fe_q, fe_d, s0_q, s0_d, e0_q, e0_d;
  // rewrite pass
  logic [CW-1:0]   wp_q, wp_d;        // write pointer
  logic            ab_q, ab_d;        // head still absorbing
  logic [PW-1:0]   ms_q, ms_d, me_q, me_d;  // head entry
  logic [PW-1:0]   bs_q, bs_d, be_q, be_d;  // entry waiting to be written
  crt_pkg::result_t res_q, res_d;
  logic            rvld_q, rvld_d;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [2*PW-1:0] wdata, rdata;
  logic [PW-1:0]   rs, re;
  logic            res_free;

  crt_ram #(.DEPTH(MAX_RANGES), .AW(AW), .DW(2*PW)) u_ram (
    .clk_i(clk_i), .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign rs = rdata[2*PW-1:PW];
  assign re = rdata[PW-1:0];
  assign raddr = ri_q[AW-1:0];

  logic [PW:0] sum_w;
  assign sum_w = {1'b0, position_i[PW-1:0]} + {{(PW-31){1'b0}}, length_i};

  assign req_stall_o = (state_q != S_IDLE);
  assign res_free = !(rvld_q && res_stall_i);
  assign res_valid_o = rvld_q;
  assign hit_o = res_q.hit;
  assign range_start_o = res_q.range_start;
  assign range_size_o = res_q.range_size;
  assign available_o = res_q.available;
  assign enough_o = res_q.enough;
  assign status_o = res_q.status;

  function automatic logic [39:0] ext(input logic [PW-1:0] v);
    logic [63:0] t;
    t = 64'(v);
    return t[39:0];
  endfunction

  // Next state: accept, scan, result, rewrite pass and flush.
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    ri_d = ri_q;
    wi_d = wi_q;
    rv_d = rv_q;
    kind_d = kind_q;
    pos_d = pos_q;
    len_d = len_q;
    nend_d = nend_q;
    found_d = found_q;
    first0_d = first0_q;
    fidx_d = fidx_q;
    ins_d = ins_q;
    fs_d = fs_q;
    fe_d = fe_q;
    s0_d = s0_q;
    e0_d = e0_q;
    wp_d = wp_q;
    ab_d = ab_q;
    ms_d = ms_q;
    me_d = me_q;
    bs_d = bs_q;
    be_d = be_q;
    res_d = res_q;
    rvld_d = rvld_q && res_stall_i;
    we = 1'b0;
    waddr = wp_q[AW-1:0];
    wdata = {bs_q, be_q};
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          kind_d = kind_i;
          pos_d = position_i[PW-1:0];
          len_d = length_i;
          nend_d = (sum_w > PMAX) ? PMAX[PW-1:0] : sum_w[PW-1:0];
          found_d = 1'b0;
          ins_d = count_q;
          ri_d = '0;
          rv_d = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rv_q) begin
          if (wi_q == '0) begin
            s0_d = rs;
            e0_d = re;
            first0_d = (rs == '0);
          end
          if (!found_q && pos_q >= rs && pos_q <= re) begin
            found_d = 1'b1;
            fidx_d = wi_q;
            fs_d = rs;
            fe_d = re;
          end
          // insert point: first entry that starts after the position
          if (rs > pos_q && ins_q == count_q) ins_d = wi_q;
        end
        if (ri_q < count_q) begin
          ri_d = ri_q + CW'(1);
          wi_d = ri_q;
          rv_d = 1'b1;
        end else begin
          rv_d = 1'b0;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (res_free) begin
          res_d = '0;
          rvld_d = 1'b1;
          state_d = S_IDLE;
          if (kind_q == crt_pkg::KIND_LOOKUP) begin
            if (found_q) begin
              res_d.hit = 1'b1;
              res_d.range_start = ext(fs_q);
              res_d.range_size = ext(fe_q - fs_q);
              res_d.available = ext(fe_q - pos_q);
              res_d.enough = (fe_q - pos_q) >= PW'(len_q);
            end
          end else if (kind_q == crt_pkg::KIND_INFO) begin
            res_d.hit = found_q;
            if (found_q) res_d.available = ext(fe_q - pos_q);
            if (count_q != '0 && first0_q) begin
              res_d.range_start = found_q ? ext(fs_q) : ext(s0_q);
              res_d.range_size = found_q ? ext(fe_q - fs_q) : ext(e0_q - s0_q);
            end
          end else if (kind_q == crt_pkg::KIND_WRITE) begin
            res_d.hit = found_q;
            if (found_q && nend_q <= fe_q) begin
              res_d.range_start = ext(fs_q);
              res_d.range_size = ext(fe_q - fs_q);
            end else if (!found_q && count_q >= FULL) begin
              res_d.status = 1'b1;
            end else begin
              // rewrite from the head entry: extended or newly inserted
              rvld_d = 1'b0;
              state_d = S_PASS;
              ri_d = found_q ? fidx_q + CW'(1) : ins_q;
              rv_d = 1'b0;
              wp_d = found_q ? fidx_q : ins_q;
              ab_d = 1'b1;
              ms_d = found_q ? fs_q : pos_q;
              me_d = nend_q;
            end
          end
        end
      end
      S_PASS: begin
        // entries the new end reaches fold into the head; the rest move
        if (rv_q) begin
          if (ab_q && rs <= nend_q) begin
            if (re > me_q) me_d = re;
          end else if (ab_q) begin
            we = 1'b1;
            wdata = {ms_q, me_q};
            wp_d = wp_q + CW'(1);
            ab_d = 1'b0;
            bs_d = rs;
            be_d = re;
          end else begin
            we = 1'b1;
            wp_d = wp_q + CW'(1);
            bs_d = rs;
            be_d = re;
          end
        end
        if (ri_q < count_q) begin
          ri_d = ri_q + CW'(1);
          wi_d = ri_q;
          rv_d = 1'b1;
        end else begin
          rv_d = 1'b0;
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        // last write: the head if nothing followed it, else the held entry
        if (res_free) begin
          we = 1'b1;
          if (ab_q) wdata = {ms_q, me_q};
          count_d = wp_q + CW'(1);
          res_d = '0;
          res_d.hit = found_q;
          res_d.range_start = ext(ms_q);
          res_d.range_size = ext(me_q - ms_q);
          rvld_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      ri_q <= '0;
      wi_q <= '0;
      rv_q <= 1'b0;
      kind_q <= '0;
      pos_q <= '0;
      len_q <= '0;
      nend_q <= '0;
      found_q <= 1'b0;
      first0_q <= 1'b0;
      fidx_q <= '0;
      ins_q <= '0;
      fs_q <= '0;
      fe_q <= '0;
      s0_q <= '0;
      e0_q <= '0;
      wp_q <= '0;
      ab_q <= 1'b0;
      ms_q <= '0;
      me_q <= '0;
      bs_q <= '0;
      be_q <= '0;
      res_q <= '0;
      rvld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ri_q <= ri_d;
      wi_q <= wi_d;
      rv_q <= rv_d;
      kind_q <= kind_d;
      pos_q <= pos_d;
      len_q <= len_d;
      nend_q <= nend_d;
      found_q <= found_d;
      first0_q <= first0_d;
      fidx_q <= fidx_d;
      ins_q <= ins_d;
      fs_q <= fs_d;
      fe_q <= fe_d;
      s0_q <= s0_d;
      e0_q <= e0_d;
      wp_q <= wp_d;
      ab_q <= ab_d;
      ms_q <= ms_d;
      me_q <= me_d;
      bs_q <= bs_d;
      be_q <= be_d;
      res_q <= res_d;
      rvld_q <= rvld_d;
    end
  end

endmodule
